// File: rtl/tps_pkg.sv
package tps_pkg;

    localparam int FREQ_W     = 16;
    localparam int MS_W       = 16;
    localparam int PAT_W      = 4;
    localparam int IDX_W      = 4;
    localparam int NUM_PAT    = 9;
    localparam int MAX_STEPS  = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ENABLED = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_TONE = 2'd1,
        OP_PLAY = 2'd2,
        OP_STOP = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [FREQ_W-1:0]   tone_freq;
        logic [MS_W-1:0]     tone_ms;
        logic [PAT_W-1:0]    pattern_id;
    } t_cmd;

    typedef struct packed {
        logic [FREQ_W-1:0]   sounding_freq;
        logic                busy_res;
        logic [PAT_W-1:0]    active_pattern;
    } t_res;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [MS_W-1:0]     dur;
    } t_step;

    localparam logic [FREQ_W-1:0] ROM_FREQ [0:NUM_PAT][0:MAX_STEPS-1] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd988, 16'd1319, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd262, 16'd196, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd523, 16'd659, 16'd784, 16'd1047, 16'd1319, 16'd1568,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1319, 16'd1568, 16'd2637, 16'd2093, 16'd2349, 16'd3136,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd523, 16'd659, 16'd784, 16'd1047, 16'd784, 16'd659,
          16'd523, 16'd587, 16'd698, 16'd880, 16'd1175, 16'd0},
        '{16'd2000, 16'd0, 16'd2000, 16'd0, 16'd2000, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd800, 16'd0, 16'd800, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd523, 16'd659, 16'd784, 16'd1047, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd200, 16'd0, 16'd150, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    localparam logic [MS_W-1:0] ROM_DUR [0:NUM_PAT][0:MAX_STEPS-1] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd100, 16'd400, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd50, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd60, 16'd60, 16'd60, 16'd60, 16'd60, 16'd200,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd300,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd150, 16'd150, 16'd150, 16'd300, 16'd150, 16'd150,
          16'd300, 16'd150, 16'd150, 16'd150, 16'd400, 16'd0},
        '{16'd100, 16'd50, 16'd100, 16'd50, 16'd100, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd200, 16'd100, 16'd200, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd100, 16'd100, 16'd100, 16'd200, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd200, 16'd100, 16'd300, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    // out-of-range pattern or index reads as the terminator
    function automatic t_step rom_step(input logic [PAT_W-1:0] pat,
                                       input logic [IDX_W-1:0] idx);
        t_step s;
        s = '0;
        if (pat <= PAT_W'(NUM_PAT) && idx < IDX_W'(MAX_STEPS)) begin
            s.freq = ROM_FREQ[pat][idx];
            s.dur  = ROM_DUR[pat][idx];
        end
        return s;
    endfunction

endpackage

// File: rtl/tps_cmd_if.sv
interface tps_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [tps_pkg::FREQ_W-1:0]    tone_freq;
    logic [tps_pkg::MS_W-1:0]      tone_ms;
    logic [tps_pkg::PAT_W-1:0]     pattern_id;

    modport source (output valid, output opcode, output tone_freq, output tone_ms,
                    output pattern_id, input ready);
    modport sink   (input valid, input opcode, input tone_freq, input tone_ms,
                    input pattern_id, output ready);
endinterface

// File: rtl/tps_res_if.sv
interface tps_res_if;
    logic                          valid;
    logic                          ready;
    logic [tps_pkg::FREQ_W-1:0]    sounding_freq;
    logic                          busy_res;
    logic [tps_pkg::PAT_W-1:0]     active_pattern;

    modport source (output valid, output sounding_freq, output busy_res,
                    output active_pattern, input ready);
    modport sink   (input valid, input sounding_freq, input busy_res,
                    input active_pattern, output ready);
endinterface

// File: rtl/tps_cfg.sv
module tps_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [tps_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tps_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic                              o_enabled
);

    logic r_enabled;
    logic n_enabled;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_enabled = r_enabled;
        if (wr_en && paddr[2] == tps_pkg::REG_ENABLED) begin
            n_enabled = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else begin
            r_enabled <= n_enabled;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tps_pkg::REG_ENABLED) begin
            prdata[0] = r_enabled;
        end
    end

    assign o_enabled = r_enabled;

endmodule

// File: rtl/tps_core.sv
module tps_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic            i_enabled,
    input  tps_pkg::t_cmd   i_cmd,
    output tps_pkg::t_res   o_res
);

    logic [tps_pkg::FREQ_W-1:0] r_current_freq, n_current_freq;
    logic [tps_pkg::MS_W-1:0]   r_tone_left, n_tone_left;
    logic                       r_tone_timed, n_tone_timed;
    logic [tps_pkg::PAT_W-1:0]  r_pattern_now, n_pattern_now;
    logic [tps_pkg::IDX_W-1:0]  r_step_index, n_step_index;
    logic [tps_pkg::MS_W-1:0]   r_step_elapsed, n_step_elapsed;

    tps_pkg::t_step             cur_step;
    tps_pkg::t_step             nxt_step;
    tps_pkg::t_step             first_step;
    logic [tps_pkg::IDX_W-1:0]  nxt_idx;
    logic [tps_pkg::MS_W-1:0]   elapsed_inc;
    logic                       do_stop;
    logic                       pat_bad;

    assign nxt_idx     = r_step_index + 1'b1;
    assign cur_step    = tps_pkg::rom_step(r_pattern_now, r_step_index);
    assign nxt_step    = tps_pkg::rom_step(r_pattern_now, nxt_idx);
    assign first_step  = tps_pkg::rom_step(i_cmd.pattern_id, '0);
    assign elapsed_inc = (r_step_elapsed != '1) ? r_step_elapsed + 1'b1 : r_step_elapsed;
    assign pat_bad     = (i_cmd.pattern_id == '0)
                      || (i_cmd.pattern_id > tps_pkg::PAT_W'(tps_pkg::NUM_PAT));

    always_comb begin
        n_current_freq = r_current_freq;
        n_tone_left    = r_tone_left;
        n_tone_timed   = r_tone_timed;
        n_pattern_now  = r_pattern_now;
        n_step_index   = r_step_index;
        n_step_elapsed = r_step_elapsed;
        do_stop        = 1'b0;
        case (i_cmd.opcode)
            tps_pkg::OP_TICK: begin
                if (r_tone_timed && r_tone_left <= tps_pkg::MS_W'(1)) begin
                    do_stop = 1'b1;
                end else begin
                    if (r_tone_timed) begin
                        n_tone_left = r_tone_left - 1'b1;
                    end
                    if (r_pattern_now != '0) begin
                        if (cur_step.freq == '0 && cur_step.dur == '0) begin
                            do_stop = 1'b1;
                        end else if (elapsed_inc >= cur_step.dur) begin
                            // step boundary: pause steps load a zero frequency
                            if (nxt_step.freq == '0 && nxt_step.dur == '0) begin
                                do_stop = 1'b1;
                            end else begin
                                n_step_index   = nxt_idx;
                                n_step_elapsed = '0;
                                n_current_freq = nxt_step.freq;
                            end
                        end else begin
                            n_step_elapsed = elapsed_inc;
                        end
                    end
                end
            end
            tps_pkg::OP_TONE: begin
                if (i_enabled) begin
                    if (i_cmd.tone_freq == '0) begin
                        do_stop = 1'b1;
                    end else begin
                        n_current_freq = i_cmd.tone_freq;
                        n_tone_timed   = (i_cmd.tone_ms != '0);
                        n_tone_left    = i_cmd.tone_ms;
                    end
                end
            end
            tps_pkg::OP_PLAY: begin
                if (pat_bad) begin
                    do_stop = 1'b1;
                end else begin
                    n_pattern_now  = i_cmd.pattern_id;
                    n_step_index   = '0;
                    n_step_elapsed = '0;
                    // first step sounds untimed, only when enabled
                    if (i_enabled && first_step.freq != '0) begin
                        n_current_freq = first_step.freq;
                        n_tone_timed   = 1'b0;
                        n_tone_left    = '0;
                    end
                end
            end
            default: begin
                do_stop = 1'b1;
            end
        endcase
        if (do_stop) begin
            n_current_freq = '0;
            n_tone_left    = '0;
            n_tone_timed   = 1'b0;
            n_pattern_now  = '0;
            n_step_index   = '0;
            n_step_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_freq <= '0;
            r_tone_left    <= '0;
            r_tone_timed   <= 1'b0;
            r_pattern_now  <= '0;
            r_step_index   <= '0;
            r_step_elapsed <= '0;
        end else if (i_advance) begin
            r_current_freq <= n_current_freq;
            r_tone_left    <= n_tone_left;
            r_tone_timed   <= n_tone_timed;
            r_pattern_now  <= n_pattern_now;
            r_step_index   <= n_step_index;
            r_step_elapsed <= n_step_elapsed;
        end
    end

    assign o_res.sounding_freq  = n_current_freq;
    assign o_res.busy_res       = (n_current_freq != '0) || (n_pattern_now != '0);
    assign o_res.active_pattern = n_pattern_now;

    a_timed_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone_timed |-> r_tone_left != '0)
        else $error("timed tone with no time left");

    a_pattern_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern_now <= tps_pkg::PAT_W'(tps_pkg::NUM_PAT))
        else $error("pattern number out of range");

    a_idle_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern_now == '0 |-> r_step_index == '0 && r_step_elapsed == '0)
        else $error("step cursor set with no pattern");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_cmd.opcode == tps_pkg::OP_STOP
        |=> r_current_freq == '0 && r_pattern_now == '0 && !r_tone_timed)
        else $error("stop left state behind");

endmodule

// File: rtl/tone_pattern_sequencer.sv
// channel   dir  handshake      payload
// i_cmd     in   valid/ready    opcode, tone_freq, tone_ms, pattern_id
// o_res     out  valid/ready    sounding_freq, busy_res, active_pattern
// apb       in   psel/penable   paddr, pwdata, prdata (enabled at 0x0)
//
// one beat per cycle sustained while o_res.ready is high; a command beat
// passes through the input register, then the result register
// state update and ROM step lookups are one combinational pass per beat
// reset (i_rst_n low, synchronous) clears enabled, all sequencer state, valids
// a stalled result holds; a second command still lands in the input register
module tone_pattern_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tps_cmd_if.sink                           i_cmd,
    tps_res_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [tps_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tps_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic           r_in_valid;
    tps_pkg::t_cmd  r_in;
    logic           r_res_valid;
    tps_pkg::t_res  r_res;
    logic           advance;
    logic           enabled;
    tps_pkg::t_res  core_res;

    assign advance     = r_in_valid && (!r_res_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.opcode     <= tps_pkg::t_opcode'(i_cmd.opcode);
            r_in.tone_freq  <= i_cmd.tone_freq;
            r_in.tone_ms    <= i_cmd.tone_ms;
            r_in.pattern_id <= i_cmd.pattern_id;
        end
        if (advance) begin
            r_res <= core_res;
        end
    end

    tps_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_enabled (enabled)
    );

    tps_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_enabled (enabled),
        .i_cmd     (r_in),
        .o_res     (core_res)
    );

    assign o_res.valid          = r_res_valid;
    assign o_res.sounding_freq  = r_res.sounding_freq;
    assign o_res.busy_res       = r_res.busy_res;
    assign o_res.active_pattern = r_res.active_pattern;

endmodule
